FILE: rtl/rlse_pkg.sv
// ----------------------------------------------------------------------------
// rlse_pkg
// Shared types and constants of the register-list stack engine: command
// codes, list slot numbers, sequencer states, address unit controls and the
// packed layouts of the request and response words.
// ----------------------------------------------------------------------------
package rlse_pkg;

   // defaults for the top level parameters
   localparam int unsigned STACK_BYTES_DEF       = 65536;
   localparam int unsigned MAX_OPERAND_BYTES_DEF = 8;

   // stack pointer width and remainder step counter width
   localparam int unsigned PTR_W   = 16;
   localparam int unsigned RED_K_W = 3;

   // segment registers keep only their low nibble
   localparam logic [15:0] SEGMENT_MASK = 16'h000F;

   // halfword slots of a register list
   localparam int unsigned NUM_SLOTS = 6;
   localparam int unsigned SLOT_W    = 3;

   // push list order
   localparam logic [SLOT_W-1:0] PUSH_SLOT_ECSR = 3'd0;
   localparam logic [SLOT_W-1:0] PUSH_SLOT_ELR  = 3'd1;
   localparam logic [SLOT_W-1:0] PUSH_SLOT_EPSW = 3'd2;
   localparam logic [SLOT_W-1:0] PUSH_SLOT_LCSR = 3'd3;
   localparam logic [SLOT_W-1:0] PUSH_SLOT_LR   = 3'd4;
   localparam logic [SLOT_W-1:0] PUSH_SLOT_EA   = 3'd5;

   // pop list order
   localparam logic [SLOT_W-1:0] POP_SLOT_EA   = 3'd0;
   localparam logic [SLOT_W-1:0] POP_SLOT_LR   = 3'd1;
   localparam logic [SLOT_W-1:0] POP_SLOT_LCSR = 3'd2;
   localparam logic [SLOT_W-1:0] POP_SLOT_PSW  = 3'd3;
   localparam logic [SLOT_W-1:0] POP_SLOT_PC   = 3'd4;
   localparam logic [SLOT_W-1:0] POP_SLOT_CSR  = 3'd5;

   // reg_list mask bits
   localparam int unsigned LIST_EA  = 0;
   localparam int unsigned LIST_PC  = 1;
   localparam int unsigned LIST_PSW = 2;
   localparam int unsigned LIST_LR  = 3;

   typedef enum logic [2:0] {
      CMD_PUSH      = 3'd0,
      CMD_POP       = 3'd1,
      CMD_PUSH_LIST = 3'd2,
      CMD_POP_LIST  = 3'd3,
      CMD_SET_SP    = 3'd4
   } rlse_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DOWN,
      ST_WRITE,
      ST_READ,
      ST_LIST,
      ST_REDUCE,
      ST_DRAIN,
      ST_RESP
   } rlse_state_type;

   // address unit operations
   typedef enum logic [2:0] {
      AOP_HOLD,
      AOP_LOAD,
      AOP_UP,
      AOP_DOWN,
      AOP_RED_LOAD,
      AOP_RED_STEP
   } rlse_aop_type;

   typedef struct packed {
      rlse_aop_type      op;
      logic [PTR_W-1:0]  load_ptr;
   } rlse_au_ctrl_type;

   typedef struct packed {
      logic [PTR_W-1:0]  next_ptr;
      logic              red_last;
   } rlse_au_stat_type;

   // request word, lowest field at the bottom
   typedef struct packed {
      logic [15:0] saved_epsw;
      logic [3:0]  saved_ecsr;
      logic [15:0] saved_elr;
      logic [3:0]  link_segment;
      logic [15:0] link_value;
      logic [15:0] ea_value;
      logic [3:0]  reg_list;
      logic [63:0] operand_value;
      logic [3:0]  operand_size;
   } rlse_req_type;

   // response word, lowest field at the bottom, padded to whole bytes
   typedef struct packed {
      logic [3:0]  pad;
      logic [15:0] stack_pointer_out;
      logic [3:0]  loaded_mask;
      logic [3:0]  popped_csr;
      logic [15:0] popped_pc;
      logic [15:0] popped_psw;
      logic [3:0]  popped_lcsr;
      logic [15:0] popped_lr;
      logic [15:0] popped_ea;
      logic [63:0] popped_value;
   } rlse_rsp_type;

   localparam int unsigned REQ_DATA_W = $bits(rlse_req_type);
   localparam int unsigned RSP_DATA_W = $bits(rlse_rsp_type);
   localparam int unsigned CMD_W      = 3;

endpackage

FILE: rtl/rlse_stack_ram.sv
// ----------------------------------------------------------------------------
// rlse_stack_ram
// Byte-wide single-port stack memory with registered read data.
// ----------------------------------------------------------------------------
module rlse_stack_ram #(
   parameter int unsigned DEPTH = rlse_pkg::STACK_BYTES_DEF,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          we,
   input  logic          re,
   input  logic [AW-1:0] addr,
   input  logic [7:0]    wdata,
   output logic [7:0]    rdata
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   // one access per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/rlse_addr_unit.sv
// ----------------------------------------------------------------------------
// rlse_addr_unit
// Shared address unit: walks a 16-bit stack address up or down by one byte
// while keeping its memory index (address modulo stack size), and reduces a
// freshly loaded pointer to its index by restoring compare-subtract steps.
// ----------------------------------------------------------------------------
module rlse_addr_unit #(
   parameter int unsigned STACK_BYTES = rlse_pkg::STACK_BYTES_DEF,
   parameter int unsigned AW          = $clog2(STACK_BYTES)
) (
   input  logic                      clock,
   input  rlse_pkg::rlse_au_ctrl_type ctrl,
   input  logic [AW-1:0]             load_phys,
   output rlse_pkg::rlse_au_stat_type stat,
   output logic [AW-1:0]             phys,
   output logic [AW-1:0]             next_phys
);

   localparam int unsigned PW        = rlse_pkg::PTR_W;
   localparam int unsigned KW        = rlse_pkg::RED_K_W;
   localparam int unsigned MAX_QUOT  = ((1 << PW) - 1) / STACK_BYTES;
   localparam int unsigned RED_STEPS = (MAX_QUOT == 0) ? 1 : $clog2(MAX_QUOT + 1);
   localparam int unsigned CMP_W     = PW + (1 << KW);
   localparam logic [AW-1:0] LAST_PHYS = AW'(STACK_BYTES - 1);
   localparam logic [AW-1:0] TOP_PHYS  = AW'(((1 << PW) - 1) % STACK_BYTES);
   localparam logic [CMP_W-1:0] DIVISOR = CMP_W'(STACK_BYTES);

   logic [PW-1:0]    ptr_ff, ptr_in;
   logic [AW-1:0]    phys_ff, phys_in;
   logic [PW-1:0]    rem_ff, rem_in;
   logic [KW-1:0]    k_ff, k_in;
   logic [CMP_W-1:0] trial, rem_wide, rem_sub;
   logic [AW-1:0]    up_phys, down_phys;

   // one restoring step of the remainder
   always_comb begin
      trial    = DIVISOR << k_ff;
      rem_wide = CMP_W'(rem_ff);
      rem_sub  = (rem_wide >= trial) ? (rem_wide - trial) : rem_wide;
   end

   // index one byte up or down, following the 16-bit wrap
   always_comb begin
      if (ptr_ff == '1 || phys_ff == LAST_PHYS) begin
         up_phys = '0;
      end else begin
         up_phys = phys_ff + AW'(1);
      end
      if (ptr_ff == '0) begin
         down_phys = TOP_PHYS;
      end else if (phys_ff == '0) begin
         down_phys = LAST_PHYS;
      end else begin
         down_phys = phys_ff - AW'(1);
      end
   end

   // operation select
   always_comb begin
      ptr_in  = ptr_ff;
      phys_in = phys_ff;
      rem_in  = rem_ff;
      k_in    = k_ff;
      case (ctrl.op)
         rlse_pkg::AOP_HOLD: begin
         end
         rlse_pkg::AOP_LOAD: begin
            ptr_in  = ctrl.load_ptr;
            phys_in = load_phys;
         end
         rlse_pkg::AOP_UP: begin
            ptr_in  = ptr_ff + PW'(1);
            phys_in = up_phys;
         end
         rlse_pkg::AOP_DOWN: begin
            ptr_in  = ptr_ff - PW'(1);
            phys_in = down_phys;
         end
         rlse_pkg::AOP_RED_LOAD: begin
            ptr_in = ctrl.load_ptr;
            rem_in = ctrl.load_ptr;
            k_in   = KW'(RED_STEPS - 1);
         end
         rlse_pkg::AOP_RED_STEP: begin
            rem_in = rem_sub[PW-1:0];
            k_in   = k_ff - KW'(1);
            if (k_ff == '0) begin
               phys_in = rem_sub[AW-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      phys_ff <= phys_in;
      rem_ff  <= rem_in;
      k_ff    <= k_in;
   end

   assign stat.next_ptr = ptr_in;
   assign stat.red_last = (k_ff == '0);
   assign phys          = phys_ff;
   assign next_phys     = phys_in;

endmodule

FILE: rtl/register_list_stack_engine.sv
// A one-byte push or pop moves the stack pointer by 2 bytes, a larger one by its
// size; a register list moves up to 6 halfwords. One byte per cycle moves through
// the single memory port under the shared address unit; a new request can be
// taken in the same cycle that the response word is first valid.
// Reset: synchronous, clears stack pointer and model bit; stack RAM is not cleared.
// ----------------------------------------------------------------------------
// register_list_stack_engine
// Stack unit of a small 16-bit CPU: push/pop of 1 to 8 byte registers,
// push/pop of register lists, and stack pointer load, on a byte-wide RAM.
// ----------------------------------------------------------------------------
module register_list_stack_engine #(
   parameter int unsigned STACK_BYTES       = rlse_pkg::STACK_BYTES_DEF,
   parameter int unsigned MAX_OPERAND_BYTES = rlse_pkg::MAX_OPERAND_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // operand_size, operand_value, reg_list, ea_value, link_value,
   // link_segment, saved_elr, saved_ecsr, saved_epsw
   input  logic [rlse_pkg::REQ_DATA_W-1:0] req_tdata,
   // command
   input  logic [rlse_pkg::CMD_W-1:0]      req_tuser,
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // popped_value, popped_ea, popped_lr, popped_lcsr, popped_psw,
   // popped_pc, popped_csr, loaded_mask, stack_pointer_out, zero pad
   output logic [rlse_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // configuration: large_model
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_data
);

   localparam int unsigned AW = $clog2(STACK_BYTES);
   localparam int unsigned PW = rlse_pkg::PTR_W;
   localparam int unsigned SW = rlse_pkg::SLOT_W;
   localparam int unsigned NS = rlse_pkg::NUM_SLOTS;

   rlse_pkg::rlse_state_type state_ff, state_in;
   rlse_pkg::rlse_req_type   req_word;
   rlse_pkg::rlse_cmd_type   req_cmd;
   rlse_pkg::rlse_cmd_type   cmd_ff, cmd_in;
   rlse_pkg::rlse_rsp_type   rsp_data_ff, rsp_data_in;
   rlse_pkg::rlse_au_ctrl_type au_ctrl;
   rlse_pkg::rlse_au_stat_type au_stat;

   logic          accept;
   logic          large_ff, large_in;
   logic [PW-1:0] sp_ff, sp_in;
   logic [AW-1:0] sp_phys_ff, sp_phys_in;
   logic          sp_load;
   logic [AW-1:0] au_phys, au_next_phys, au_load_phys;

   // per-item payload
   logic [3:0]    size_ff, size_in, step_ff, step_in, req_size;
   logic [63:0]   value_ff, value_in;
   logic [3:0]    list_ff, list_in;
   logic [15:0]   ea_ff, ea_in, lr_ff, lr_in, elr_ff, elr_in, epsw_ff, epsw_in;
   logic [3:0]    lcsr_ff, lcsr_in, ecsr_ff, ecsr_in;

   // sequencer counters
   logic [2:0]    cnt_ff, cnt_in;
   logic          half_ff, half_in;
   logic [NS-1:0] pend_ff, pend_in, pend_clear;
   logic [SW-1:0] cur_slot;
   logic          last_step;
   logic [15:0]   slot_half;

   // memory port
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_addr;
   logic [7:0]    mem_wdata, mem_rdata;

   // read tags, registered alongside the memory read data
   logic          rd_pend_ff, rd_pend_in;
   logic          rd_list_ff, rd_list_in;
   logic [2:0]    rd_byte_ff, rd_byte_in;
   logic [SW-1:0] rd_slot_ff, rd_slot_in;
   logic          rd_half_ff, rd_half_in;

   // result accumulators
   logic [63:0]   acc_value_ff, acc_value_in;
   logic [15:0]   acc_ea_ff, acc_ea_in, acc_lr_ff, acc_lr_in;
   logic [15:0]   acc_psw_ff, acc_psw_in, acc_pc_ff, acc_pc_in;
   logic [3:0]    acc_lcsr_ff, acc_lcsr_in, acc_csr_ff, acc_csr_in;
   logic [3:0]    seg_nibble;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_free, rsp_load;

   assign req_word   = req_tdata;
   assign req_cmd    = rlse_pkg::rlse_cmd_type'(req_tuser);
   assign req_tready = (state_ff == rlse_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign last_step  = ({1'b0, cnt_ff} == (step_ff - 4'd1));

   // size clamp: zero acts as one, large sizes saturate
   always_comb begin
      if (req_word.operand_size == 4'd0) begin
         req_size = 4'd1;
      end else if (req_word.operand_size > 4'(MAX_OPERAND_BYTES)) begin
         req_size = 4'(MAX_OPERAND_BYTES);
      end else begin
         req_size = req_word.operand_size;
      end
   end

   // lowest pending list slot
   always_comb begin
      cur_slot = '0;
      for (int s = NS - 1; s >= 0; s--) begin
         if (pend_ff[s]) begin
            cur_slot = SW'(s);
         end
      end
      pend_clear = pend_ff & ~(NS'(1) << cur_slot);
   end

   // halfword of the current push slot
   always_comb begin
      case (cur_slot)
         rlse_pkg::PUSH_SLOT_ECSR: slot_half = {12'd0, ecsr_ff};
         rlse_pkg::PUSH_SLOT_ELR:  slot_half = elr_ff;
         rlse_pkg::PUSH_SLOT_EPSW: slot_half = epsw_ff;
         rlse_pkg::PUSH_SLOT_LCSR: slot_half = {12'd0, lcsr_ff};
         rlse_pkg::PUSH_SLOT_LR:   slot_half = lr_ff;
         rlse_pkg::PUSH_SLOT_EA:   slot_half = ea_ff;
         default:                  slot_half = '0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rlse_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  rlse_pkg::CMD_PUSH:      state_in = rlse_pkg::ST_DOWN;
                  rlse_pkg::CMD_POP:       state_in = rlse_pkg::ST_READ;
                  rlse_pkg::CMD_PUSH_LIST: state_in = rlse_pkg::ST_LIST;
                  rlse_pkg::CMD_POP_LIST:  state_in = rlse_pkg::ST_LIST;
                  rlse_pkg::CMD_SET_SP:    state_in = rlse_pkg::ST_REDUCE;
                  default:                 state_in = rlse_pkg::ST_RESP;
               endcase
            end
         end
         rlse_pkg::ST_DOWN: begin
            if (last_step) begin
               state_in = rlse_pkg::ST_WRITE;
            end
         end
         rlse_pkg::ST_WRITE: begin
            if ({1'b0, cnt_ff} == (size_ff - 4'd1)) begin
               state_in = rlse_pkg::ST_RESP;
            end
         end
         rlse_pkg::ST_READ: begin
            if (last_step) begin
               state_in = rlse_pkg::ST_DRAIN;
            end
         end
         rlse_pkg::ST_LIST: begin
            if (pend_ff == '0) begin
               state_in = (cmd_ff == rlse_pkg::CMD_POP_LIST) ? rlse_pkg::ST_DRAIN
                                                             : rlse_pkg::ST_RESP;
            end
         end
         rlse_pkg::ST_REDUCE: begin
            if (au_stat.red_last) begin
               state_in = rlse_pkg::ST_RESP;
            end
         end
         rlse_pkg::ST_DRAIN: begin
            state_in = rlse_pkg::ST_RESP;
         end
         rlse_pkg::ST_RESP: begin
            if (rsp_free) begin
               state_in = rlse_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rlse_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      au_ctrl.op       = rlse_pkg::AOP_HOLD;
      au_ctrl.load_ptr = sp_ff;
      au_load_phys     = sp_phys_ff;
      sp_load          = 1'b0;
      mem_we           = 1'b0;
      mem_re           = 1'b0;
      mem_addr         = au_phys;
      mem_wdata        = value_ff[{cnt_ff, 3'b000} +: 8];
      cnt_in           = cnt_ff;
      half_in          = half_ff;
      pend_in          = pend_ff;
      rd_list_in       = 1'b0;
      rd_byte_in       = cnt_ff;
      rd_slot_in       = cur_slot;
      rd_half_in       = half_ff;
      rsp_load         = 1'b0;
      case (state_ff)
         rlse_pkg::ST_IDLE: begin
            cnt_in  = '0;
            half_in = 1'b0;
            if (accept) begin
               if (req_cmd == rlse_pkg::CMD_SET_SP) begin
                  au_ctrl.op       = rlse_pkg::AOP_RED_LOAD;
                  au_ctrl.load_ptr = req_word.operand_value[PW-1:0];
               end else begin
                  au_ctrl.op = rlse_pkg::AOP_LOAD;
               end
               if (req_cmd == rlse_pkg::CMD_PUSH_LIST) begin
                  pend_in = '0;
                  pend_in[rlse_pkg::PUSH_SLOT_ECSR] =
                     large_ff && req_word.reg_list[rlse_pkg::LIST_PC];
                  pend_in[rlse_pkg::PUSH_SLOT_ELR]  = req_word.reg_list[rlse_pkg::LIST_PC];
                  pend_in[rlse_pkg::PUSH_SLOT_EPSW] = req_word.reg_list[rlse_pkg::LIST_PSW];
                  pend_in[rlse_pkg::PUSH_SLOT_LCSR] =
                     large_ff && req_word.reg_list[rlse_pkg::LIST_LR];
                  pend_in[rlse_pkg::PUSH_SLOT_LR]   = req_word.reg_list[rlse_pkg::LIST_LR];
                  pend_in[rlse_pkg::PUSH_SLOT_EA]   = req_word.reg_list[rlse_pkg::LIST_EA];
               end else begin
                  pend_in = '0;
                  pend_in[rlse_pkg::POP_SLOT_EA]   = req_word.reg_list[rlse_pkg::LIST_EA];
                  pend_in[rlse_pkg::POP_SLOT_LR]   = req_word.reg_list[rlse_pkg::LIST_LR];
                  pend_in[rlse_pkg::POP_SLOT_LCSR] =
                     large_ff && req_word.reg_list[rlse_pkg::LIST_LR];
                  pend_in[rlse_pkg::POP_SLOT_PSW]  = req_word.reg_list[rlse_pkg::LIST_PSW];
                  pend_in[rlse_pkg::POP_SLOT_PC]   = req_word.reg_list[rlse_pkg::LIST_PC];
                  pend_in[rlse_pkg::POP_SLOT_CSR]  =
                     large_ff && req_word.reg_list[rlse_pkg::LIST_PC];
               end
            end
         end
         rlse_pkg::ST_DOWN: begin
            // move to the new top of stack before writing upward
            au_ctrl.op = rlse_pkg::AOP_DOWN;
            sp_load    = last_step;
            cnt_in     = last_step ? 3'd0 : (cnt_ff + 3'd1);
         end
         rlse_pkg::ST_WRITE: begin
            au_ctrl.op = rlse_pkg::AOP_UP;
            mem_we     = 1'b1;
            cnt_in     = cnt_ff + 3'd1;
         end
         rlse_pkg::ST_READ: begin
            // read size bytes, walk step bytes
            au_ctrl.op = rlse_pkg::AOP_UP;
            mem_re     = ({1'b0, cnt_ff} < size_ff);
            sp_load    = last_step;
            cnt_in     = cnt_ff + 3'd1;
         end
         rlse_pkg::ST_LIST: begin
            if (pend_ff == '0) begin
               sp_load = 1'b1;
            end else begin
               half_in = !half_ff;
               if (half_ff) begin
                  pend_in = pend_clear;
               end
               if (cmd_ff == rlse_pkg::CMD_PUSH_LIST) begin
                  // pre-decrement: high byte first, then low byte
                  au_ctrl.op = rlse_pkg::AOP_DOWN;
                  mem_we     = 1'b1;
                  mem_addr   = au_next_phys;
                  mem_wdata  = half_ff ? slot_half[7:0] : slot_half[15:8];
               end else begin
                  // post-increment: low byte first, then high byte
                  au_ctrl.op = rlse_pkg::AOP_UP;
                  mem_re     = 1'b1;
                  rd_list_in = 1'b1;
               end
            end
         end
         rlse_pkg::ST_REDUCE: begin
            au_ctrl.op = rlse_pkg::AOP_RED_STEP;
            sp_load    = au_stat.red_last;
         end
         rlse_pkg::ST_DRAIN: begin
         end
         rlse_pkg::ST_RESP: begin
            rsp_load = rsp_free;
         end
         default: begin
         end
      endcase
   end

   assign rd_pend_in = mem_re;

   // item payload capture
   always_comb begin
      cmd_in   = cmd_ff;
      size_in  = size_ff;
      step_in  = step_ff;
      value_in = value_ff;
      list_in  = list_ff;
      ea_in    = ea_ff;
      lr_in    = lr_ff;
      lcsr_in  = lcsr_ff;
      elr_in   = elr_ff;
      ecsr_in  = ecsr_ff;
      epsw_in  = epsw_ff;
      if (accept) begin
         cmd_in   = req_cmd;
         size_in  = req_size;
         step_in  = (req_size == 4'd1) ? 4'd2 : req_size;
         value_in = req_word.operand_value;
         list_in  = req_word.reg_list;
         ea_in    = req_word.ea_value;
         lr_in    = req_word.link_value;
         lcsr_in  = req_word.link_segment;
         elr_in   = req_word.saved_elr;
         ecsr_in  = req_word.saved_ecsr;
         epsw_in  = req_word.saved_epsw;
      end
   end

   // read data into the accumulators; cleared for each new item
   assign seg_nibble = 4'(16'(mem_rdata) & rlse_pkg::SEGMENT_MASK);

   always_comb begin
      acc_value_in = acc_value_ff;
      acc_ea_in    = acc_ea_ff;
      acc_lr_in    = acc_lr_ff;
      acc_lcsr_in  = acc_lcsr_ff;
      acc_psw_in   = acc_psw_ff;
      acc_pc_in    = acc_pc_ff;
      acc_csr_in   = acc_csr_ff;
      if (accept) begin
         acc_value_in = '0;
         acc_ea_in    = '0;
         acc_lr_in    = '0;
         acc_lcsr_in  = '0;
         acc_psw_in   = '0;
         acc_pc_in    = '0;
         acc_csr_in   = '0;
      end else if (rd_pend_ff && !rd_list_ff) begin
         acc_value_in[{rd_byte_ff, 3'b000} +: 8] = mem_rdata;
      end else if (rd_pend_ff) begin
         case (rd_slot_ff)
            rlse_pkg::POP_SLOT_EA: begin
               if (rd_half_ff) acc_ea_in[15:8] = mem_rdata;
               else            acc_ea_in[7:0]  = mem_rdata;
            end
            rlse_pkg::POP_SLOT_LR: begin
               if (rd_half_ff) acc_lr_in[15:8] = mem_rdata;
               else            acc_lr_in[7:0]  = mem_rdata;
            end
            rlse_pkg::POP_SLOT_LCSR: begin
               if (!rd_half_ff) acc_lcsr_in = seg_nibble;
            end
            rlse_pkg::POP_SLOT_PSW: begin
               if (rd_half_ff) acc_psw_in[15:8] = mem_rdata;
               else            acc_psw_in[7:0]  = mem_rdata;
            end
            rlse_pkg::POP_SLOT_PC: begin
               if (rd_half_ff) acc_pc_in[15:8] = mem_rdata;
               else            acc_pc_in[7:0]  = mem_rdata;
            end
            rlse_pkg::POP_SLOT_CSR: begin
               if (!rd_half_ff) acc_csr_in = seg_nibble;
            end
            default: begin
            end
         endcase
      end
   end

   // response word
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (rsp_load) begin
         rsp_data_in.pad               = '0;
         rsp_data_in.stack_pointer_out = sp_ff;
         rsp_data_in.loaded_mask       =
            (cmd_ff == rlse_pkg::CMD_POP_LIST) ? list_ff : 4'd0;
         rsp_data_in.popped_csr        = acc_csr_ff;
         rsp_data_in.popped_pc         = acc_pc_ff;
         rsp_data_in.popped_psw        = acc_psw_ff;
         rsp_data_in.popped_lcsr       = acc_lcsr_ff;
         rsp_data_in.popped_lr         = acc_lr_ff;
         rsp_data_in.popped_ea         = acc_ea_ff;
         rsp_data_in.popped_value      = acc_value_ff;
      end
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // architectural pointer and model bit
   assign sp_in      = sp_load ? au_stat.next_ptr : sp_ff;
   assign sp_phys_in = sp_load ? au_next_phys : sp_phys_ff;
   assign large_in   = csr_valid ? csr_data : large_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rlse_pkg::ST_IDLE;
         large_ff     <= 1'b0;
         sp_ff        <= '0;
         sp_phys_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         large_ff     <= large_in;
         sp_ff        <= sp_in;
         sp_phys_ff   <= sp_phys_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= rd_pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      size_ff      <= size_in;
      step_ff      <= step_in;
      value_ff     <= value_in;
      list_ff      <= list_in;
      ea_ff        <= ea_in;
      lr_ff        <= lr_in;
      lcsr_ff      <= lcsr_in;
      elr_ff       <= elr_in;
      ecsr_ff      <= ecsr_in;
      epsw_ff      <= epsw_in;
      cnt_ff       <= cnt_in;
      half_ff      <= half_in;
      pend_ff      <= pend_in;
      rd_list_ff   <= rd_list_in;
      rd_byte_ff   <= rd_byte_in;
      rd_slot_ff   <= rd_slot_in;
      rd_half_ff   <= rd_half_in;
      acc_value_ff <= acc_value_in;
      acc_ea_ff    <= acc_ea_in;
      acc_lr_ff    <= acc_lr_in;
      acc_lcsr_ff  <= acc_lcsr_in;
      acc_psw_ff   <= acc_psw_in;
      acc_pc_ff    <= acc_pc_in;
      acc_csr_ff   <= acc_csr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   rlse_addr_unit #(
      .STACK_BYTES (STACK_BYTES),
      .AW          (AW)
   ) u_addr (
      .clock     (clock),
      .ctrl      (au_ctrl),
      .load_phys (au_load_phys),
      .stat      (au_stat),
      .phys      (au_phys),
      .next_phys (au_next_phys)
   );

   rlse_stack_ram #(
      .DEPTH (STACK_BYTES),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

endmodule

FILE: rtl/rlse_checker.sv
// ----------------------------------------------------------------------------
// rlse_checker
// Port-level checks of the stack engine, bound to the top level.
// ----------------------------------------------------------------------------
module rlse_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rlse_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // one item at a time: busy right after an accepted request word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while an item is in progress");

   // a restored link segment implies LR in the loaded mask
   a_lcsr_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[99:96] != 4'd0) |-> rsp_tdata[139])
      else $error("link segment restored without LR in the mask");

   // a restored code segment implies PC in the loaded mask
   a_csr_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[135:132] != 4'd0) |-> rsp_tdata[137])
      else $error("code segment restored without PC in the mask");

endmodule

bind register_list_stack_engine rlse_checker u_rlse_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
